// ===== src/fdt_pkg.sv =====
// Package for the factorial divisibility test unit.
// Holds the value width, derived widths and the divider request/response types.
// No dependencies.
package fdt_pkg;

  localparam int unsigned VALUE_BITS = 31;
  // Trial divisor width: d stays below 2^((VALUE_BITS+1)/2 + 1)
  localparam int unsigned DW  = (VALUE_BITS + 1) / 2 + 1;
  // d squared width
  localparam int unsigned SQW = VALUE_BITS + 1;
  // Exponent width: an exponent never exceeds VALUE_BITS
  localparam int unsigned EW  = $clog2(VALUE_BITS + 1);
  // Divider bit counter width
  localparam int unsigned CW  = $clog2(VALUE_BITS + 1);

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [VALUE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] rem;
  } div_rsp_t;

endpackage

// ===== src/fdt_if.sv =====
// Valid/ready channel interfaces for the factorial divisibility test unit.
// Depends on fdt_pkg for the value width.
interface fdt_in_if;
  logic                          valid;
  logic                          ready;
  logic [fdt_pkg::VALUE_BITS-1:0] factorial_arg;
  logic [fdt_pkg::VALUE_BITS-1:0] candidate_divisor;

  modport source (output valid, factorial_arg, candidate_divisor, input ready);
  modport sink   (input valid, factorial_arg, candidate_divisor, output ready);
endinterface

interface fdt_out_if;
  logic valid;
  logic ready;
  logic divides;

  modport source (output valid, divides, input ready);
  modport sink   (input valid, divides, output ready);
endinterface

// ===== src/fdt_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Shared by trial division and the Legendre sums. Depends on fdt_pkg.
module fdt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fdt_pkg::div_req_t req_i,
  output fdt_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = fdt_pkg::VALUE_BITS;

  logic                   busy_q, done_q;
  logic [fdt_pkg::CW-1:0] cnt_q;
  logic [W-1:0]           acc_q, quo_q, dvs_q;

  logic [W:0] partial;
  logic [W:0] diff;
  logic       ge;

  always_comb begin
    partial = {acc_q, quo_q[W-1]};
    diff    = partial - {1'b0, dvs_q};
    ge      = (partial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (req_i.start) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= fdt_pkg::CW'(W);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= (cnt_q != fdt_pkg::CW'(1));
        done_q <= (cnt_q == fdt_pkg::CW'(1));
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= ge ? diff[W-1:0] : partial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = acc_q;

endmodule

// ===== src/factorial_divisibility_test_unit.sv =====
// Factorial divisibility test unit: sequencer around one shared divider.
// Depends on fdt_pkg, fdt_in_if/fdt_out_if and fdt_div.
//
// Usage:
//   in_i carries a word (factorial_arg = n, candidate_divisor = m); out_o returns one
//   word per input, divides = 1 when m divides n!, else 0. m = 0 gives 0, m = 1 gives 1.
//   m is factored by trial division with 2 and the odd numbers while d*d <= cofactor;
//   for each prime factor p^e, Legendre's sum of floor(n/p^k) is built by repeated
//   division of n by p and compared against e, stopping as soon as it reaches e.
//   A leftover cofactor above 1 is a prime of exponent 1.
// Cost:
//   Every division runs on the single radix-2 divider, so the work grows with the
//   number of divisions: one per trial divisor, one more per factor found, plus the
//   Legendre terms. A prime m near 2^31 needs about 23000 trial divisors.
// Reset and stall:
//   Reset (rst_ni low) returns the sequencer to idle and drops out_o.valid.
//   The result sits in an output register; the next input is taken while it waits.
//   If a second result finishes before the first is taken, the sequencer holds it.
module factorial_divisibility_test_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  fdt_in_if.sink      in_i,
  fdt_out_if.source   out_o
);

  localparam int unsigned W = fdt_pkg::VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_FWAIT,
    S_LWAIT,
    S_NEXT,
    S_FIN
  } state_e;

  state_e                  state_q;
  logic [W-1:0]            n_q, rem_q, p_q, total_q;
  logic [fdt_pkg::DW-1:0]  d_q;
  logic [fdt_pkg::SQW-1:0] sq_q;
  logic [fdt_pkg::EW-1:0]  e_q;
  logic                    ok_q, tail_q;
  logic                    out_valid_q, divides_q;
  fdt_pkg::div_req_t       req_q;
  fdt_pkg::div_rsp_t       rsp;

  logic [W:0] tot_sum;
  logic       tot_ok;
  logic       out_free;
  logic       start_d;

  fdt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  always_comb begin
    tot_sum = {1'b0, total_q} + {1'b0, rsp.quot};
    tot_ok  = (tot_sum >= (W+1)'(e_q));
  end

  // divider launch, one pulse per division
  always_comb begin
    out_free = !out_valid_q || out_o.ready;
    case (state_q)
      S_TEST:  start_d = (sq_q <= {1'b0, rem_q}) || (rem_q > W'(1));
      S_FWAIT: start_d = rsp.done && ((rsp.rem == '0) || (e_q != '0));
      S_LWAIT: start_d = rsp.done && !tot_ok && (rsp.quot != '0);
      default: start_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      rem_q       <= '0;
      p_q         <= '0;
      total_q     <= '0;
      d_q         <= '0;
      sq_q        <= '0;
      e_q         <= '0;
      ok_q        <= 1'b0;
      tail_q      <= 1'b0;
      out_valid_q <= 1'b0;
      divides_q   <= 1'b0;
      req_q       <= '0;
    end else begin
      req_q.start <= start_d;
      out_valid_q <= ((state_q == S_FIN) && out_free) || (out_valid_q && !out_o.ready);
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            n_q   <= in_i.factorial_arg;
            rem_q <= in_i.candidate_divisor;
            d_q   <= fdt_pkg::DW'(2);
            sq_q  <= fdt_pkg::SQW'(4);
            if (in_i.candidate_divisor == '0) begin
              ok_q    <= 1'b0;
              state_q <= S_FIN;
            end else begin
              ok_q    <= 1'b1;
              state_q <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (sq_q <= {1'b0, rem_q}) begin
            e_q            <= '0;
            req_q.dividend <= rem_q;
            req_q.divisor  <= W'(d_q);
            state_q        <= S_FWAIT;
          end else if (rem_q > W'(1)) begin
            // leftover cofactor is prime
            p_q            <= rem_q;
            e_q            <= fdt_pkg::EW'(1);
            total_q        <= '0;
            tail_q         <= 1'b1;
            req_q.dividend <= n_q;
            req_q.divisor  <= rem_q;
            state_q        <= S_LWAIT;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_FWAIT: begin
          if (rsp.done) begin
            if (rsp.rem == '0) begin
              rem_q          <= rsp.quot;
              e_q            <= e_q + 1'b1;
              req_q.dividend <= rsp.quot;
              req_q.divisor  <= W'(d_q);
            end else if (e_q != '0) begin
              p_q            <= W'(d_q);
              total_q        <= '0;
              tail_q         <= 1'b0;
              req_q.dividend <= n_q;
              req_q.divisor  <= W'(d_q);
              state_q        <= S_LWAIT;
            end else begin
              state_q <= S_NEXT;
            end
          end
        end
        S_LWAIT: begin
          // each quotient is floor(n / p^k); stop once the sum reaches e
          if (rsp.done) begin
            if (tot_ok) begin
              state_q <= tail_q ? S_FIN : S_NEXT;
            end else if (rsp.quot == '0) begin
              ok_q    <= 1'b0;
              state_q <= S_FIN;
            end else begin
              total_q        <= tot_sum[W-1:0];
              req_q.dividend <= rsp.quot;
              req_q.divisor  <= p_q;
            end
          end
        end
        S_NEXT: begin
          if (d_q == fdt_pkg::DW'(2)) begin
            d_q  <= fdt_pkg::DW'(3);
            sq_q <= fdt_pkg::SQW'(9);
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            d_q  <= d_q + fdt_pkg::DW'(2);
            sq_q <= sq_q + fdt_pkg::SQW'({d_q, 2'b00}) + fdt_pkg::SQW'(4);
          end
          state_q <= S_TEST;
        end
        S_FIN: begin
          if (out_free) begin
            divides_q <= ok_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.divides = divides_q;

endmodule

// ===== src/fdt_checker.sv =====
// Port-level checks for the factorial divisibility test unit, bound to the top level.
// Depends on fdt_pkg for the value width.
module fdt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [fdt_pkg::VALUE_BITS-1:0] cand_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          divides_i
);

  // one word at a time: ready drops right after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while busy");

  // zero divisor with a free output answers 0 by way of S_FIN and the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (cand_i == '0) && !out_valid_i)
      |-> ##2 (out_valid_i && !divides_i))
    else $error("zero divisor result wrong or late");

  // result held under backpressure
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(divides_i)))
    else $error("result dropped or changed while stalled");

  // a result appears only after some word has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i) || $past(in_valid_i))
    else $error("result without input");

endmodule

bind factorial_divisibility_test_unit fdt_checker u_fdt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .cand_i      (in_i.candidate_divisor),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .divides_i   (out_o.divides)
);

// ===== tb/sv/testbench.sv =====
// Testbench for factorial_divisibility_test_unit: directed and random (n, m) words.
// Expected verdicts come from a trial-division/Legendre predictor kept in this file.
// Depends on fdt_pkg, fdt_in_if, fdt_out_if and the unit under test.
module testbench;

  localparam int unsigned VB = fdt_pkg::VALUE_BITS;
  localparam longint unsigned VMASK = (64'd1 << VB) - 1;
  localparam int unsigned N_RANDOM = 76;
  localparam int unsigned TAIL_CYCLES = 8 * (VB + 4);
  localparam int unsigned MAX_TRIAL_OPS = 600;
  localparam int unsigned N_PRIMES = 15;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SRC_IDLE,
    PH_SNK_STALL,
    PH_BOTH
  } traffic_e;

  typedef struct {
    logic [VB-1:0] n;
    logic [VB-1:0] m;
    traffic_e      traffic;
    bit            wait_drain;
  } query_t;

  typedef struct {
    logic [VB-1:0] n;
    logic [VB-1:0] m;
    bit            divides;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  fdt_in_if  in_if();
  fdt_out_if out_if();

  factorial_divisibility_test_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  query_t          query_q[$];
  verdict_t        verdict_q[$];
  traffic_e        cur_traffic;
  bit              in_taken;
  int unsigned     n_errors;
  longint unsigned cycle_count;
  longint unsigned cycle_limit;
  int unsigned     primes[N_PRIMES] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};

  // Exponent of p in n!; terms counts the divisions the unit may spend on it.
  function automatic longint unsigned legendre_exp(input longint unsigned n,
                                                    input longint unsigned p,
                                                    output int unsigned terms);
    longint unsigned total;
    longint unsigned pw;
    total = 0;
    pw = p;
    terms = 0;
    if (p < 2) return 0;
    while (pw <= n) begin
      total += n / pw;
      terms++;
      if (pw > n / p) break;
      pw *= p;
    end
    return total;
  endfunction

  function automatic bit divides_factorial(input logic [VB-1:0] n_in,
                                           input logic [VB-1:0] m_in,
                                           output int unsigned ops);
    longint unsigned n;
    longint unsigned rem;
    longint unsigned d;
    longint unsigned e;
    int unsigned     t;
    bit              ok;
    n = n_in;
    rem = m_in;
    d = 2;
    ok = 1'b1;
    ops = 0;
    if (rem == 0) return 1'b0;
    while (ok && d * d <= rem) begin
      e = 0;
      t = 0;
      ops++;
      while (rem % d == 0) begin
        rem /= d;
        e++;
        ops++;
      end
      if (e != 0 && legendre_exp(n, d, t) < e) ok = 1'b0;
      ops += t;
      d = (d == 2) ? 3 : d + 2;
    end
    t = 0;
    if (ok && rem > 1 && legendre_exp(n, rem, t) < 1) ok = 1'b0;
    ops += t;
    return ok;
  endfunction

  function automatic int unsigned idle_pct(input traffic_e tr, input bit sink_side);
    case (tr)
      PH_SRC_IDLE:  return sink_side ? 0 : 60;
      PH_SNK_STALL: return sink_side ? 60 : 0;
      PH_BOTH:      return 37;
      default:      return 0;
    endcase
  endfunction

  task automatic add_query(input longint unsigned n, input longint unsigned m,
                           input traffic_e tr, input bit drain);
    query_t      q;
    int unsigned ops;
    q.n = n[VB-1:0];
    q.m = m[VB-1:0];
    q.traffic = tr;
    q.wait_drain = drain;
    void'(divides_factorial(q.n, q.m, ops));
    cycle_limit += longint'(ops + 8) * (VB + 4) * 4 + 300;
    query_q = {query_q, q};
  endtask

  function automatic longint unsigned pick_arg();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(64);
      4, 5, 6:    return $urandom_range(65535);
      default:    return {32'd0, $urandom} & VMASK;
    endcase
  endfunction

  // Smooth m: product of small primes, so it can span all bits but factors fast.
  function automatic longint unsigned pick_smooth();
    longint unsigned prod;
    int unsigned     cnt;
    int unsigned     p;
    prod = 1;
    cnt = $urandom_range(1, 14);
    for (int i = 0; i < cnt; i++) begin
      p = primes[$urandom_range(N_PRIMES - 1)];
      if (prod * p > VMASK) break;
      prod *= p;
    end
    return prod;
  endfunction

  function automatic longint unsigned pick_divisor();
    longint unsigned m;
    int unsigned     ops;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(4095);
      4, 5, 6, 7: return pick_smooth();
      default: begin
        // Full-width m, kept only when its trial division stays short
        for (int k = 0; k < 20; k++) begin
          m = {32'd0, $urandom} & VMASK;
          void'(divides_factorial(VMASK[VB-1:0], m[VB-1:0], ops));
          if (ops <= MAX_TRIAL_OPS) return m;
        end
        return pick_smooth();
      end
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Word driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (query_q.size() == 0 || (query_q[0].wait_drain && verdict_q.size() != 0) ||
          $urandom_range(99) < idle_pct(query_q[0].traffic, 1'b0)) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.valid <= 1'b1;
        in_if.factorial_arg <= query_q[0].n;
        in_if.candidate_divisor <= query_q[0].m;
        cur_traffic <= query_q[0].traffic;
        query_q.delete(0);
      end
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= idle_pct(cur_traffic, 1'b1));
  end

  // Monitor: result check first, then record the newly accepted word
  always @(posedge clk_i) begin
    verdict_t    exp_v;
    int unsigned ops;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("result divides=%0b with no word pending", out_if.divides));
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_if.divides !== exp_v.divides)
            note_mismatch($sformatf("n=%0d m=%0d: divides expected %0b, got %0b",
                                    exp_v.n, exp_v.m, exp_v.divides, out_if.divides));
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_taken = 1'b1;
        exp_v.n = in_if.factorial_arg;
        exp_v.m = in_if.candidate_divisor;
        exp_v.divides = divides_factorial(exp_v.n, exp_v.m, ops);
        verdict_q = {verdict_q, exp_v};
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    traffic_e tr;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.factorial_arg = '0;
    in_if.candidate_divisor = '0;
    out_if.ready = 1'b0;
    cur_traffic = PH_STEADY;
    in_taken = 1'b0;
    n_errors = 0;
    cycle_count = 0;
    cycle_limit = 5000;

    // Zero divisor, unit divisor, zero argument
    add_query(0, 0, PH_STEADY, 1'b0);
    add_query(0, 1, PH_STEADY, 1'b0);
    add_query(0, 2, PH_STEADY, 1'b0);
    add_query(1, 1, PH_STEADY, 1'b0);
    add_query(1, 2, PH_STEADY, 1'b0);
    add_query(5, 0, PH_STEADY, 1'b0);
    add_query(VMASK, 0, PH_STEADY, 1'b0);
    add_query(VMASK, 1, PH_STEADY, 1'b0);
    // 2^31-2 = 2*3^2*7*11*31*151*331, all upper bits set
    add_query(VMASK, VMASK - 1, PH_STEADY, 1'b0);
    add_query(0, VMASK - 1, PH_STEADY, 1'b0);
    add_query(330, VMASK - 1, PH_STEADY, 1'b0);
    add_query(331, VMASK - 1, PH_STEADY, 1'b0);
    // repeated factor needing several Legendre terms
    add_query(3, 8, PH_STEADY, 1'b0);
    add_query(4, 8, PH_STEADY, 1'b0);
    add_query(31, 64'd1 << 30, PH_STEADY, 1'b0);
    add_query(32, 64'd1 << 30, PH_STEADY, 1'b0);
    add_query(VMASK, 64'd1 << 30, PH_STEADY, 1'b0);
    add_query(41, 1162261467, PH_STEADY, 1'b0);
    add_query(42, 1162261467, PH_STEADY, 1'b0);
    add_query(13, 49, PH_STEADY, 1'b0);
    add_query(14, 49, PH_STEADY, 1'b0);
    // leftover cofactor treated as a prime
    add_query(9972, 19946, PH_STEADY, 1'b0);
    add_query(9973, 19946, PH_STEADY, 1'b0);
    add_query(6, 7, PH_STEADY, 1'b0);
    add_query(7, 7, PH_STEADY, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      tr = traffic_e'((i * 4) / N_RANDOM);
      add_query(pick_arg(), pick_divisor(), tr, (i % (N_RANDOM / 4)) == 0);
    end

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (query_q.size() != 0 || in_if.valid);
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fdt_pkg.sv
src/fdt_if.sv
src/fdt_div.sv
src/factorial_divisibility_test_unit.sv
src/fdt_checker.sv
tb/sv/testbench.sv
